### rtl/lrgd_pkg.sv
// shared types and constants for the regression trainer
package lrgd_pkg;

    localparam int QW = 32;
    localparam int Q_SHIFT = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BIAS   = 2'd3;

    localparam logic signed [QW-1:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [QW-1:0] S32_MIN = 32'sh80000000;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_INIT,
        OP_CLEAR_SUMS,
        OP_READ,
        OP_PRED,
        OP_ERR,
        OP_GRAD,
        OP_ACCUM,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_SCALE,
        OP_UPDATE
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic [10:0] addr;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic signed [QW-1:0] x_value;
        logic signed [QW-1:0] y_value;
        logic                 last_sample;
    } sample_t;

    typedef struct packed {
        logic signed [QW-1:0] weight;
        logic signed [QW-1:0] bias;
        logic                 samples_dropped;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [QW-1:0]        data;
    } cfg_req_t;

    function automatic logic signed [QW-1:0] sat32(input logic signed [SUM_W:0] v);
        logic signed [QW-1:0] r;
        if (v > $signed({{(SUM_W-QW+1){1'b0}}, S32_MAX}))
            r = S32_MAX;
        else if (v < $signed({{(SUM_W-QW+1){1'b1}}, S32_MIN}))
            r = S32_MIN;
        else
            r = v[QW-1:0];
        return r;
    endfunction

endpackage

### rtl/lrgd_if.sv
// valid/ready channel interfaces
interface lrgd_sample_if;
    logic                    valid;
    logic                    ready;
    lrgd_pkg::sample_t       payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lrgd_result_if;
    logic                    valid;
    logic                    ready;
    lrgd_pkg::result_t       payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lrgd_cfg_if;
    logic                    valid;
    logic                    ready;
    lrgd_pkg::cfg_req_t      payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/lrgd_datapath.sv
// sample store, gradient arithmetic, serial divider and weight update
module lrgd_datapath #(
    parameter int MAX_SAMPLES = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrgd_pkg::dp_cmd_t             cmd,
    output lrgd_pkg::dp_status_t          status,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic signed [31:0]            wr_x,
    input  logic signed [31:0]            wr_y,
    input  logic [CW-1:0]                 count,
    input  logic [15:0]                   learning_rate,
    input  logic signed [31:0]            initial_weight,
    input  logic signed [31:0]            initial_bias,
    output logic signed [31:0]            weight,
    output logic signed [31:0]            bias
);
    import lrgd_pkg::*;

    logic signed [31:0] feat_mem [MAX_SAMPLES];
    logic signed [31:0] targ_mem [MAX_SAMPLES];
    logic signed [31:0] x_reg, y_reg;
    logic signed [31:0] w_reg, b_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] err_reg;
    logic signed [63:0] sw_reg, sb_reg;
    // divider: one sum at a time, sel_reg picks which
    logic               sel_reg;
    logic [63:0]        quo_reg;
    logic [CW-1:0]      rem_reg;
    logic [6:0]         dcnt_reg;
    logic               dneg_reg;
    logic signed [31:0] avg_reg;
    logic signed [47:0] step_reg;

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            feat_mem[wr_addr] <= wr_x;
            targ_mem[wr_addr] <= wr_y;
        end
        if (cmd.op == OP_READ)
        begin
            x_reg <= feat_mem[cmd.addr[AW-1:0]];
            y_reg <= targ_mem[cmd.addr[AW-1:0]];
        end
    end

    logic signed [64:0] pred_full;
    logic signed [64:0] err_full;
    logic [CW:0]        rem_try;
    logic signed [64:0] quo_signed;
    logic signed [64:0] upd_full;

    always_comb
    begin
        pred_full = 65'(prod_reg >>> Q_SHIFT) + 65'(b_reg);
        err_full = 65'(y_reg) - pred_full;
        rem_try = {rem_reg, quo_reg[63]};
        quo_signed = dneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        upd_full = sel_reg ? 65'(b_reg) + 65'(step_reg >>> Q_SHIFT)
                           : 65'(w_reg) + 65'(step_reg >>> Q_SHIFT);
    end

    // arithmetic sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            sel_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD_INIT:
                begin
                    w_reg <= initial_weight;
                    b_reg <= initial_bias;
                end
                OP_CLEAR_SUMS:
                begin
                    sw_reg <= '0;
                    sb_reg <= '0;
                end
                OP_PRED:  prod_reg <= x_reg * w_reg;
                OP_ERR:   err_reg <= sat32(err_full);
                OP_GRAD:  prod_reg <= x_reg * err_reg;
                OP_ACCUM:
                begin
                    sw_reg <= sw_reg + ((prod_reg >>> Q_SHIFT) <<< 1);
                    sb_reg <= sb_reg + (64'(err_reg) <<< 1);
                end
                OP_DIV_START:
                begin
                    sel_reg  <= cmd.addr[0];
                    quo_reg  <= cmd.addr[0] ? (sb_reg[63] ? 64'(-sb_reg) : 64'(sb_reg))
                                            : (sw_reg[63] ? 64'(-sw_reg) : 64'(sw_reg));
                    dneg_reg <= cmd.addr[0] ? sb_reg[63] : sw_reg[63];
                    rem_reg  <= '0;
                    dcnt_reg <= 7'd64;
                end
                OP_DIV_STEP:
                begin
                    if (dcnt_reg != 0)
                    begin
                        if (rem_try >= {1'b0, count})
                        begin
                            rem_reg <= CW'(rem_try - {1'b0, count});
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_try[CW-1:0];
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - 7'd1;
                    end
                    else
                        avg_reg <= sat32(quo_signed);
                end
                OP_SCALE: step_reg <= $signed({1'b0, learning_rate}) * avg_reg;
                OP_UPDATE:
                begin
                    if (sel_reg)
                        b_reg <= sat32(upd_full);
                    else
                        w_reg <= sat32(upd_full);
                end
                default: ;
            endcase
        end
    end

    assign status.div_done = (dcnt_reg == 0);
    assign weight = w_reg;
    assign bias   = b_reg;
endmodule

### rtl/lrgd_ctrl.sv
// controller: load, pass loop, per-sample sequence, output
module lrgd_ctrl #(
    parameter int MAX_SAMPLES = 64,
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [CW-1:0]        count,
    output logic                 overflow,
    input  logic [15:0]          pass_count,
    output lrgd_pkg::dp_cmd_t    cmd,
    input  lrgd_pkg::dp_status_t status,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import lrgd_pkg::*;

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_PRED  = 4'd4;
    localparam logic [3:0] S_ERR   = 4'd5;
    localparam logic [3:0] S_GRAD  = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_DIVS  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_SCALE = 4'd10;
    localparam logic [3:0] S_UPD   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [15:0]   pass_reg, pass_next;
    logic          sel_reg, sel_next;
    logic          full;
    logic          take;

    assign full = (cnt_reg == CW'(MAX_SAMPLES));
    assign in_ready = (state_reg == S_LOAD);
    assign take = in_valid && in_ready;
    assign wr_en = take && !full;
    assign wr_addr = cnt_reg[AW-1:0];
    assign count = cnt_reg;
    assign overflow = ovf_reg;
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            pass_reg  <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
            sel_reg   <= sel_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NONE;
        cmd.addr   = 11'(idx_reg);
        unique case (state_reg)
            S_LOAD:
            begin
                if (take)
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                        cnt_next = cnt_reg + CW'(1);
                    if (in_last)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.op = OP_LOAD_INIT;
                pass_next = pass_count;
                state_next = (pass_count == 16'd0 || cnt_reg == '0) ? S_OUT : S_CLR;
            end
            S_CLR:
            begin
                cmd.op = OP_CLEAR_SUMS;
                idx_next = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.op = OP_READ;
                state_next = S_PRED;
            end
            S_PRED:  begin cmd.op = OP_PRED; state_next = S_ERR; end
            S_ERR:   begin cmd.op = OP_ERR;  state_next = S_GRAD; end
            S_GRAD:  begin cmd.op = OP_GRAD; state_next = S_ACC; end
            S_ACC:
            begin
                cmd.op = OP_ACCUM;
                idx_next = idx_reg + CW'(1);
                sel_next = 1'b0;
                state_next = (idx_reg + CW'(1) == cnt_reg) ? S_DIVS : S_READ;
            end
            S_DIVS:
            begin
                cmd.op = OP_DIV_START;
                cmd.addr = 11'(sel_reg);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_done)
                    state_next = S_SCALE;
            end
            S_SCALE: begin cmd.op = OP_SCALE; state_next = S_UPD; end
            S_UPD:
            begin
                cmd.op = OP_UPDATE;
                if (!sel_reg)
                begin
                    sel_next = 1'b1;
                    state_next = S_DIVS;
                end
                else
                begin
                    pass_next = pass_reg - 16'd1;
                    state_next = (pass_reg == 16'd1) ? S_OUT : S_CLR;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end
endmodule

### rtl/linear_regression_gradient_descent.sv
// top level: full-batch gradient descent trainer for y = w*x + b
//
//  channel   dir  payload
//  samples   in   x_value, y_value, last_sample
//  result    out  weight, bias, samples_dropped
//  cfg       in   index (0..3), data
//
// the samples channel accepts one sample per cycle while loading; each pass of a
// run then issues one clear, five steps per sample for the N stored samples and
// two divide/scale/update legs, first for the weight and then for the bias, using
// the shared multiplier and the bit-serial 64-step divider used twice per pass.
// reset clears the controller and presets the cfg registers; the store needs no clear.
// no sample is accepted while training or while a result waits.
module linear_regression_gradient_descent #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    lrgd_sample_if.sink   samples,
    lrgd_result_if.source result,
    lrgd_cfg_if.sink      cfg
);
    import lrgd_pkg::*;

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic [15:0]        lr_reg, pc_reg;
    logic signed [31:0] iw_reg, ib_reg;
    dp_cmd_t            cmd;
    dp_status_t         status;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [CW-1:0]      count;
    logic               overflow;
    logic signed [31:0] w, b;

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg <= 16'd655;
            pc_reg <= 16'd10;
            iw_reg <= 32'sd655360;
            ib_reg <= 32'sd0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_LEARNING_RATE:  lr_reg <= cfg.payload.data[15:0];
                REG_PASS_COUNT:     pc_reg <= cfg.payload.data[15:0];
                REG_INITIAL_WEIGHT: iw_reg <= cfg.payload.data;
                REG_INITIAL_BIAS:   ib_reg <= cfg.payload.data;
                default: ;
            endcase
        end
    end

    lrgd_ctrl #(.MAX_SAMPLES(MAX_SAMPLES), .AW(AW), .CW(CW)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(samples.valid), .in_last(samples.payload.last_sample),
        .in_ready(samples.ready),
        .wr_en(wr_en), .wr_addr(wr_addr), .count(count), .overflow(overflow),
        .pass_count(pc_reg), .cmd(cmd), .status(status),
        .out_valid(result.valid), .out_ready(result.ready)
    );

    lrgd_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .AW(AW), .CW(CW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_x(samples.payload.x_value), .wr_y(samples.payload.y_value),
        .count(count), .learning_rate(lr_reg),
        .initial_weight(iw_reg), .initial_bias(ib_reg),
        .weight(w), .bias(b)
    );

    assign result.payload.weight = w;
    assign result.payload.bias = b;
    assign result.payload.samples_dropped = overflow;

`ifndef SYNTHESIS
    // no sample is taken while a result waits
    a_no_take_out: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !samples.ready) else $error("sample taken during output");
    // result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(w) && $stable(b))
        else $error("result changed while stalled");
    // count never exceeds capacity
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(MAX_SAMPLES)) else $error("count over capacity");
`endif
endmodule
